// File: src/magic_frame_parser_crc32_assert.svh
// Assertion macros for the frame parser.
`ifndef MAGIC_FRAME_PARSER_CRC32_ASSERT_SVH
`define MAGIC_FRAME_PARSER_CRC32_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define MFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Check an implication in the next cycle.
`define MFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/mfp_pkg.sv
package mfp_pkg;
  localparam int MaxPayloadBytes = 32;
  localparam int StoreBytes = 56;
  localparam int HdrLen = 24;
  localparam int PtrW = $clog2(StoreBytes);
  localparam int CntW = $clog2(StoreBytes + 1);
  localparam logic [31:0] CrcPoly = 32'hedb88320;

  localparam logic [1:0] KIND_HDR_ERR = 2'd0;
  localparam logic [1:0] KIND_CRC_ERR = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  localparam logic [0:0] CFG_VERSION = 1'b0;
  localparam logic [0:0] CFG_TYPE = 1'b1;

  // Control between sequencer and CRC unit.
  typedef struct packed {
    logic init;
    logic load;
    logic [7:0] data;
  } crc_ctl_t;

  // Advance CRC register by one bit.
  function automatic logic [31:0] crc_bit(input logic [31:0] c);
    crc_bit = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
  endfunction
endpackage

// File: src/mfp_crc.sv
module mfp_crc
  import mfp_pkg::*;
(
  input  logic        clk,
  input  crc_ctl_t    ctl,
  output logic [31:0] crc,
  output logic        busy
);
  logic [31:0] c;
  logic [3:0] bits;

  // One bit a cycle; load xors a byte in and starts eight shifts.
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      c <= 32'hffffffff;
      bits <= 4'd0;
    end else if (ctl.load) begin
      c <= crc_bit(c ^ {24'd0, ctl.data});
      bits <= 4'd7;
    end else if (bits != 4'd0) begin
      c <= crc_bit(c);
      bits <= bits - 4'd1;
    end
  end

  assign crc = c;
  assign busy = (bits != 4'd0);
endmodule

// File: src/magic_frame_parser_crc32.sv
// Flow: each byte is accepted, stored and then scanned; the scan returns to idle while fewer
// than four are held. Magic bytes 0..3 are checked first and a mismatch drops the oldest byte;
// then the header is read to byte 23 and decoded, and the CRC is fed 16 header bytes plus payload
// and left to settle. Throughput: one byte per scan; each payload word waits for its byte read
// and for the sink; not ready while scanning or emitting, and a stalled output holds the sequencer.
// Reset: rst clears fill count and sequencer, and sets version and type registers to 1.
`include "magic_frame_parser_crc32_assert.svh"
module magic_frame_parser_crc32
  import mfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // transaction[31:0], offset[63:32], byte count[69:64], payload_byte[77:70], zero fill
  output logic [79:0] m_tdata,
  output logic [2:0]  m_tuser,   // kind[1:0], byte_valid[2]
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FULL = 9'b000000010,
    S_SCAN = 9'b000000100,
    S_HDR  = 9'b000001000,
    S_CRC  = 9'b000010000,
    S_CHK  = 9'b000100000,
    S_EMIT = 9'b001000000,
    S_WAIT = 9'b010000000,
    S_WR   = 9'b100000000
  } state_t;

  state_t state;
  logic [7:0] mem [StoreBytes];
  logic [PtrW-1:0] head;        // ring start = oldest byte
  logic [CntW-1:0] fill;
  logic [7:0] ver_reg, type_reg, in_byte;
  logic [5:0] idx;              // header/payload position being read
  logic [7:0] rd;
  logic [7:0] hdr [24];
  logic [5:0] plen;
  logic [5:0] emit_i;
  logic hdr_done;
  logic [1:0] err_kind;
  crc_ctl_t cctl;
  logic [31:0] crc;
  logic crc_busy;

  mfp_crc u_crc (.clk(clk), .ctl(cctl), .crc(crc), .busy(crc_busy));

  function automatic logic [PtrW-1:0] wrap(input logic [PtrW-1:0] h, input logic [6:0] o);
    logic [7:0] s;
    s = {{(8-PtrW){1'b0}}, h} + {1'b0, o};
    if (s >= 8'(StoreBytes)) s = s - 8'(StoreBytes);
    return s[PtrW-1:0];
  endfunction

  logic [PtrW-1:0] rd_addr;
  assign rd_addr = wrap(head, {1'b0, idx});
  always_ff @(posedge clk) rd <= mem[rd_addr];

  logic [15:0] f_hsz, f_plen, f_res;
  logic [31:0] f_crc, f_tr, f_of;
  assign f_hsz = {hdr[7], hdr[6]};
  assign f_plen = {hdr[17], hdr[16]};
  assign f_res = {hdr[19], hdr[18]};
  assign f_crc = {hdr[23], hdr[22], hdr[21], hdr[20]};
  assign f_tr = {hdr[11], hdr[10], hdr[9], hdr[8]};
  assign f_of = {hdr[15], hdr[14], hdr[13], hdr[12]};
  logic hdr_bad;
  assign hdr_bad = hdr[4] != ver_reg || hdr[5] != type_reg ||
                   f_hsz != 16'(HdrLen) || f_plen > 16'(MaxPayloadBytes) || f_res != 16'd0;

  // idx pipeline: rd holds byte at idx of previous cycle
  logic [5:0] idx_q;
  logic rd_ok;

  assign s_tready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    cctl = '0;
    cctl.data = rd;
    if (state == S_HDR && !hdr_done) cctl.init = 1'b1;
    if (state == S_CRC && rd_ok && !crc_busy) cctl.load = 1'b1;
  end

  logic [5:0] crc_end;
  assign crc_end = 6'(HdrLen) + plen;

  // Last CRC byte: byte 19 for an empty frame, else the final payload byte.
  logic crc_last;
  assign crc_last = (plen == 6'd0) ? (idx_q == 6'd19) : (idx_q == crc_end - 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      head <= '0;
      ver_reg <= 8'd1;
      type_reg <= 8'd1;
      m_tvalid <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              CFG_VERSION: ver_reg <= cfg_data;
              CFG_TYPE: type_reg <= cfg_data;
            endcase
          end else if (s_tvalid) begin
            in_byte <= s_tdata;
            if (fill == CntW'(StoreBytes)) begin
              // full: report and drop oldest before storing
              err_kind <= KIND_HDR_ERR;
              head <= wrap(head, 7'd1);
              fill <= fill - CntW'(1);
              state <= S_FULL;
            end else state <= S_WR;
          end
        end
        S_FULL: if (!m_tvalid) begin
          m_tvalid <= 1'b1;
          m_tdata <= '0;
          m_tuser <= {1'b0, KIND_HDR_ERR};
          m_tlast <= 1'b0;
          state <= S_WR;
        end
        S_WR: begin
          mem[wrap(head, {1'b0, fill})] <= in_byte;
          fill <= fill + CntW'(1);
          idx <= 6'd0;
          rd_ok <= 1'b0;
          hdr_done <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // read magic bytes 0..3 then header to 23
          if (fill < CntW'(4)) state <= S_IDLE;
          else begin
            rd_ok <= 1'b1;
            idx_q <= idx;
            idx <= idx + 6'd1;
            if (rd_ok) hdr[idx_q[4:0]] <= rd;
            if (rd_ok && idx_q <= 6'd3 && rd != (idx_q == 6'd0 ? 8'h4d :
                idx_q == 6'd1 ? 8'h44 : idx_q == 6'd2 ? 8'h46 : 8'h55)) begin
              head <= wrap(head, 7'd1);
              fill <= fill - CntW'(1);
              idx <= 6'd0;
              rd_ok <= 1'b0;
            end else if (rd_ok && idx_q == 6'd3 && fill < CntW'(HdrLen)) begin
              state <= S_IDLE;
            end else if (rd_ok && idx_q == 6'(HdrLen - 1)) begin
              hdr_done <= 1'b0;
              state <= S_HDR;
            end
          end
        end
        S_HDR: begin
          if (!hdr_done) begin
            hdr_done <= 1'b1;
            plen <= f_plen[5:0];
          end else if (hdr_bad) begin
            err_kind <= KIND_HDR_ERR;
            state <= S_WAIT;
          end else if (fill < crc_end) begin
            state <= S_IDLE;
          end else begin
            idx <= 6'd4;
            rd_ok <= 1'b0;
            idx_q <= 6'd0;
            state <= S_CRC;
          end
        end
        S_CRC: begin
          // feed bytes 4..19 then payload; skip 20..23
          if (!crc_busy) begin
            if (rd_ok) begin
              // the CRC unit takes rd this cycle
              rd_ok <= 1'b0;
              if (crc_last) state <= S_CHK;
              else idx <= (idx_q == 6'd19) ? 6'(HdrLen) : idx_q + 6'd1;
            end else begin
              rd_ok <= 1'b1;
              idx_q <= idx;
            end
          end
        end
        S_CHK: if (!crc_busy) begin
          if ((crc ^ 32'hffffffff) != f_crc) begin
            err_kind <= KIND_CRC_ERR;
            state <= S_WAIT;
          end else begin
            emit_i <= 6'd0;
            idx <= 6'(HdrLen);
            rd_ok <= 1'b0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          rd_ok <= 1'b1;
          if (rd_ok && !m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata <= {2'd0, (plen != 6'd0) ? rd : 8'd0, plen, f_of, f_tr};
            m_tuser <= {plen != 6'd0, KIND_PAYLOAD};
            m_tlast <= (plen == 6'd0) || (emit_i + 6'd1 == plen);
            if ((plen == 6'd0) || (emit_i + 6'd1 == plen)) begin
              head <= wrap(head, {1'b0, crc_end});
              fill <= fill - CntW'(crc_end);
              idx <= 6'd0;
              rd_ok <= 1'b0;
              state <= S_SCAN;
            end else begin
              emit_i <= emit_i + 6'd1;
              idx <= idx + 6'd1;
              rd_ok <= 1'b0;
            end
          end
        end
        S_WAIT: if (!m_tvalid) begin
          m_tvalid <= 1'b1;
          m_tdata <= '0;
          m_tuser <= {1'b0, err_kind};
          m_tlast <= 1'b0;
          head <= wrap(head, 7'd1);
          fill <= fill - CntW'(1);
          idx <= 6'd0;
          rd_ok <= 1'b0;
          state <= S_SCAN;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MFP_ASSERT_IMP(a_fill_range, 1'b1, fill <= CntW'(StoreBytes))
  `MFP_ASSERT_IMP(a_ready_idle, s_tready, state == S_IDLE)
  `MFP_ASSERT_NEXT(a_accept_leaves, s_tvalid && s_tready, !s_tready)
endmodule
